// ===== rtl/core/lru_key_value_cache_top_defines.svh =====
// assertion macros shared by the lru key-value cache modules
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lkvc_pkg.sv =====
// shared constants and types of the lru key-value cache
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } cmd_t;

endpackage

// ===== rtl/core/lkvc_ctrl.sv =====
// controller state machine of the lru key-value cache
`include "lru_key_value_cache_top_defines.svh"

module lkvc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output lkvc_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r == ST_LOOKUP);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   state_nxt = accept ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = accept ? ST_LOOKUP : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.capture = accept;
  assign cmd.lookup  = (state_r == ST_LOOKUP);
  assign cmd.commit  = (state_r == ST_COMMIT);

  `LKVC_ASSERT_NEXT(a_accept_lookup, accept, state_r == ST_LOOKUP, "accepted beat not looked up")
  `LKVC_ASSERT_NEXT(a_lookup_commit, state_r == ST_LOOKUP, state_r == ST_COMMIT, "lookup without commit")
  `LKVC_ASSERT_NEXT(a_busy_single, busy, !busy, "busy held longer than one cycle")

endmodule

// ===== rtl/core/lkvc_dp.sv =====
// datapath of the lru key-value cache: entry stores, ranks, lookup and update
`include "lru_key_value_cache_top_defines.svh"

module lkvc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lkvc_pkg::cmd_t                   cmd,
  input  logic                             in_func,
  input  logic signed [lkvc_pkg::KEY_W-1:0] in_key,
  input  logic signed [lkvc_pkg::VAL_W-1:0] in_value,
  input  logic                             cfg_wr_en,
  input  logic        [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic signed [lkvc_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_evicted,
  output logic signed [lkvc_pkg::KEY_W-1:0] out_evicted_key
);

  localparam int N  = lkvc_pkg::ENTRIES;
  localparam int IW = lkvc_pkg::IDX_W;
  localparam int CW = lkvc_pkg::CNT_W;

  // first set bit of a vector
  function automatic logic [IW-1:0] first_set(input logic [N-1:0] vec);
    logic [IW-1:0] idx;
    logic          found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (vec[i] && !found) begin
        idx   = IW'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

  // capacity zero acts as one, above the entry count it is clamped
  function automatic logic [CW-1:0] eff_cap(input logic [lkvc_pkg::CAP_W-1:0] cap);
    logic [CW-1:0] c;
    if (cap == '0) begin
      c = CW'(1);
    end else if (int'(cap) > N) begin
      c = CW'(N);
    end else begin
      c = CW'(cap);
    end
    return c;
  endfunction

  // captured beat
  logic                       func_r;
  logic [lkvc_pkg::KEY_W-1:0] key_r;
  logic [lkvc_pkg::VAL_W-1:0] val_r;

  logic [lkvc_pkg::CAP_W-1:0] cap_r;

  // entry state
  logic [lkvc_pkg::KEY_W-1:0] key_store_r   [N];
  logic [lkvc_pkg::VAL_W-1:0] value_store_r [N];
  logic [N-1:0]               valid_r, valid_nxt;
  logic [IW-1:0]              rank_r   [N];
  logic [IW-1:0]              rank_nxt [N];
  logic [CW-1:0]              fill_r, fill_nxt;

  // lookup results
  logic [N-1:0]  match_vec, oldest_vec;
  logic          hit_c, evict_c;
  logic [IW-1:0] hit_idx, victim_idx, free_idx, slot_c;
  logic [IW-1:0] oldest_rank;
  logic          hit_r, evict_r;
  logic [IW-1:0] slot_r, limit_r;

  // result registers
  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [lkvc_pkg::VAL_W-1:0] out_read_value_r;
  logic                       out_evicted_r;
  logic [lkvc_pkg::KEY_W-1:0] out_evicted_key_r;

  // valid ranks are 0 .. fill-1, so the oldest holds fill-1
  assign oldest_rank = IW'(fill_r - CW'(1));

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = valid_r[i] && (key_store_r[i] == key_r);
      oldest_vec[i] = valid_r[i] && (rank_r[i] == oldest_rank);
    end
  end

  assign hit_idx    = first_set(match_vec);
  assign victim_idx = first_set(oldest_vec);
  assign free_idx   = first_set(~valid_r);
  assign hit_c      = |match_vec;
  assign evict_c    = (func_r == lkvc_pkg::FUNC_PUT) && !hit_c && (fill_r >= eff_cap(cap_r));
  assign slot_c     = hit_c ? hit_idx : (evict_c ? victim_idx : free_idx);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      key_r  <= in_key;
      val_r  <= in_value;
    end
    if (cmd.lookup) begin
      hit_r   <= hit_c;
      evict_r <= evict_c;
      slot_r  <= slot_c;
      limit_r <= rank_r[hit_idx];
    end
  end

  // rank aging, valid bits and fill count
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    fill_nxt  = fill_r;
    if (cmd.commit) begin
      if (hit_r) begin
        for (int i = 0; i < N; i++) begin
          if (valid_r[i] && (IW'(i) != slot_r) && (rank_r[i] < limit_r)) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        rank_nxt[slot_r] = '0;
      end else if (func_r == lkvc_pkg::FUNC_PUT) begin
        for (int i = 0; i < N; i++) begin
          if (valid_r[i] && (IW'(i) != slot_r)) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        rank_nxt[slot_r]  = '0;
        valid_nxt[slot_r] = 1'b1;
        if (!evict_r) begin
          fill_nxt = fill_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lkvc_pkg::CAP_RESET;
      valid_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  // stores and result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (func_r == lkvc_pkg::FUNC_PUT) begin
        value_store_r[slot_r] <= val_r;
        if (!hit_r) begin
          key_store_r[slot_r] <= key_r;
        end
      end
      out_hit_r         <= hit_r;
      out_read_value_r  <= (hit_r && (func_r == lkvc_pkg::FUNC_GET)) ? value_store_r[slot_r] : '1;
      out_evicted_r     <= evict_r;
      out_evicted_key_r <= evict_r ? key_store_r[slot_r] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  `LKVC_ASSERT_NOW(a_fill_matches, 1'b1, $countones(valid_r) == int'(fill_r), "fill count off")
  `LKVC_ASSERT_NOW(a_fill_bound, 1'b1, int'(fill_r) <= N, "fill count above entries")
  `LKVC_ASSERT_NOW(a_evict_key_zero, out_valid_r && !out_evicted_r, out_evicted_key_r == '0, "evicted key without eviction")

endmodule

// ===== rtl/core/lru_key_value_cache_top.sv =====
// top level of the lru key-value cache
//
//  channel  ports                                  handshake
//  -------  -------------------------------------  -------------------------------
//  input    in_func, in_key, in_value              start high while busy low
//  result   out_hit, out_read_value, out_evicted,  out_valid strobe, one cycle
//           out_evicted_key
//  config   cfg_wr_en, cfg_wr_data                 write when cfg_wr_en high
//
// each beat passes a lookup cycle (parallel key compare over all
// entries, oldest and free slot pick) and a commit cycle that writes
// the stores and ages the ranks; busy is high during the lookup only, so
// a new beat can be taken while the earlier beat commits; the result strobe
// comes from output registers loaded by the commit, and the result is taken at the edge ending it
// synchronous active-low reset clears valid bits, ranks and fill count, and
// sets capacity to 16; key and value stores are not cleared
// the receiver cannot stall, so every strobed result is taken as it appears
module lru_key_value_cache_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beat
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_func,
  input  logic signed [lkvc_pkg::KEY_W-1:0] in_key,
  input  logic signed [lkvc_pkg::VAL_W-1:0] in_value,
  // capacity register
  input  logic                              cfg_wr_en,
  input  logic        [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
  // result beat
  output logic                              out_valid,
  output logic                              out_hit,
  output logic signed [lkvc_pkg::VAL_W-1:0] out_read_value,
  output logic                              out_evicted,
  output logic signed [lkvc_pkg::KEY_W-1:0] out_evicted_key
);

  // sequencing commands from controller to datapath
  lkvc_pkg::cmd_t cmd;

  // controller: capture, lookup, commit sequencing
  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: entry stores, recency ranks, capacity and result registers
  lkvc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the lru key-value cache top level
`timescale 1ns / 100ps

module tb;

  typedef logic [lkvc_pkg::KEY_W-1:0] key_t;
  typedef logic [lkvc_pkg::VAL_W-1:0] value_t;
  typedef logic [lkvc_pkg::CAP_W-1:0] cap_t;

  // one result beat as the block reports it
  typedef struct packed {
    logic   hit;
    value_t read_value;
    logic   evicted;
    key_t   evicted_key;
  } access_result_t;

  // directed table rows are either an access or a capacity write
  typedef enum logic {ROW_ACCESS, ROW_CAPACITY} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic           func;
    key_t           key;
    value_t         value;   // capacity value on a capacity row
    bit             typed;   // use want instead of the predicted result
    access_result_t want;
  } stim_row_t;

  localparam int   HALF_PERIOD  = 10;
  localparam int   RESET_CYCLES = 9;
  localparam int   LIMIT_CYCLES = 200_000;
  localparam int   END_CYCLES   = 8;
  localparam int   POOL         = 24;
  localparam int   PHASES       = 8;

  localparam key_t   KEY_MIN    = 32'h8000_0000;
  localparam key_t   KEY_MAX    = 32'h7fff_ffff;
  localparam key_t   KEY_ONES   = 32'hffff_ffff;
  localparam value_t MISS_VALUE = 32'hffff_ffff;  // read value on a miss or a put
  localparam value_t FILL_VALUE = 32'h0f0f_0f0f;  // don't-care value on gets

  localparam access_result_t RESULT_MISS = '{hit: 1'b0, read_value: MISS_VALUE,
                                             evicted: 1'b0, evicted_key: '0};

  // phase plan: capacity, percent of cycles the sender idles, beats
  // capacity 0 behaves as 1, 31 saturates at the entry count
  // note: no receiver stall exists, so every phase idles only on the sender side,
  // 70% of cycles in two phases and 23% in three
  int cap_seq [PHASES] = '{16, 3, 31, 0, 8, 1, 16, 5};
  int gap_seq [PHASES] = '{0, 70, 23, 0, 70, 23, 0, 23};
  int len_seq [PHASES] = '{70, 60, 60, 50, 60, 40, 60, 50};

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   start     = 1'b0;
  logic   in_func   = lkvc_pkg::FUNC_GET;
  key_t   in_key    = '0;
  value_t in_value  = '0;
  logic   cfg_wr_en = 1'b0;
  cap_t   cfg_wr_data = '0;
  logic   busy;
  logic   out_valid;
  logic   out_hit;
  value_t out_read_value;
  logic   out_evicted;
  key_t   out_evicted_key;

  // shadow of the cache contents used for prediction
  key_t   shadow_key  [lkvc_pkg::ENTRIES];
  value_t shadow_val  [lkvc_pkg::ENTRIES];
  bit     shadow_live [lkvc_pkg::ENTRIES] = '{default: 1'b0};
  int     shadow_rank [lkvc_pkg::ENTRIES] = '{default: 0};
  int     live_count  = 0;
  cap_t   capacity_reg = lkvc_pkg::CAP_RESET;

  access_result_t results_due [$];   // one entry per accepted beat, oldest first
  access_result_t oldest_due;
  stim_row_t      stim_rows [$];
  key_t           key_pool [POOL];
  int             mismatch_count = 0;
  int             cycle_count    = 0;

  lru_key_value_cache_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

  always #HALF_PERIOD clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // capacity as the block applies it: zero acts as one, above the entry count saturates
  function automatic int usable_capacity(input cap_t cap);
    int c;
    c = cap;
    if (c == 0) c = 1;
    if (c > lkvc_pkg::ENTRIES) c = lkvc_pkg::ENTRIES;
    return c;
  endfunction

  // age every live entry younger than limit, then make slot the newest
  function automatic void make_newest(input int slot, input int limit);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (shadow_live[i] && i != slot && shadow_rank[i] < limit)
        shadow_rank[i]++;
    shadow_rank[slot] = 0;
  endfunction

  // outcome of one get or put, updating the shadow cache
  function automatic access_result_t cache_access(input logic func, input key_t key,
                                                  input value_t value);
    access_result_t r;
    int found;
    int slot;
    int oldest;
    bit any;
    r     = RESULT_MISS;
    found = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (found < 0 && shadow_live[i] && shadow_key[i] == key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (func == lkvc_pkg::FUNC_GET) r.read_value = shadow_val[found];
      else shadow_val[found] = value;
      make_newest(found, shadow_rank[found]);
    end else if (func == lkvc_pkg::FUNC_PUT) begin
      slot = 0;
      if (live_count + 1 > usable_capacity(capacity_reg) && live_count > 0) begin
        // replace the least recent entry in place
        any    = 1'b0;
        oldest = 0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
          if (shadow_live[i] && (!any || shadow_rank[i] > oldest)) begin
            oldest = shadow_rank[i];
            slot   = i;
            any    = 1'b1;
          end
        r.evicted     = 1'b1;
        r.evicted_key = shadow_key[slot];
        shadow_live[slot] = 1'b0;
      end else begin
        // lowest free slot
        for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--)
          if (!shadow_live[i]) slot = i;
        live_count++;
      end
      shadow_key[slot]  = key;
      shadow_val[slot]  = value;
      shadow_live[slot] = 1'b1;
      make_newest(slot, lkvc_pkg::ENTRIES + 1);
    end
    return r;
  endfunction

  // one input beat: optional idle cycles, then hold start until the block takes it
  task automatic send_access(input logic func, input key_t key, input value_t value,
                             input int gap_pct, input bit typed,
                             input access_result_t want);
    access_result_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = cache_access(func, key, value);
    results_due.push_back(typed ? want : predicted);
  endtask

  // hold the sender off until every outstanding beat has its result
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // capacity is only written with the block idle
  task automatic write_capacity(input cap_t cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic add_row(input row_kind_t kind, input logic func, input key_t key,
                         input value_t value, input bit typed,
                         input access_result_t want);
    stim_row_t row;
    row.kind  = kind;
    row.func  = func;
    row.key   = key;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  // mostly keys from a small pool so gets hit and puts evict; some fresh and extreme keys
  function automatic key_t pick_key(input int span);
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom;
    if (r < 11) begin
      case ($urandom_range(2))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        default: return KEY_ONES;
      endcase
    end
    return key_pool[$urandom_range(span - 1)];
  endfunction

  // result beats are taken on the edge that ends their strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("result beat with no access outstanding");
      end else begin
        oldest_due = results_due.pop_front();
        check_field("hit", 32'(out_hit), 32'(oldest_due.hit));
        check_field("read_value", out_read_value, oldest_due.read_value);
        check_field("evicted", 32'(out_evicted), 32'(oldest_due.evicted));
        check_field("evicted_key", out_evicted_key, oldest_due.evicted_key);
      end
    end
  end

  initial begin : stimulus
    int   span;
    logic func;
    foreach (key_pool[i]) key_pool[i] = $urandom;

    // directed part, block starts empty at capacity 16
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, '0, FILL_VALUE, 1'b1, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, KEY_MIN, KEY_MAX, 1'b1, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, KEY_MIN, FILL_VALUE, 1'b1,
            '{1'b1, KEY_MAX, 1'b0, 32'h0});
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, KEY_MAX, KEY_MIN, 1'b1, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, KEY_MAX, FILL_VALUE, 1'b1,
            '{1'b1, KEY_MIN, 1'b0, 32'h0});
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, KEY_ONES, '0, 1'b1, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, KEY_ONES, FILL_VALUE, 1'b1,
            '{1'b1, 32'h0, 1'b0, 32'h0});
    // update of a stored key reports a hit with no read value
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, KEY_ONES, '1, 1'b1,
            '{1'b1, MISS_VALUE, 1'b0, 32'h0});
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, KEY_ONES, FILL_VALUE, 1'b1,
            '{1'b1, 32'hffff_ffff, 1'b0, 32'h0});
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, '0, 32'h5a5a_a5a5, 1'b1, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, '0, FILL_VALUE, 1'b1,
            '{1'b1, 32'h5a5a_a5a5, 1'b0, 32'h0});
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, 32'h1, FILL_VALUE, 1'b1, RESULT_MISS);
    // capacity zero acts as one and lies below the four live entries
    add_row(ROW_CAPACITY, lkvc_pkg::FUNC_GET, '0, 32'd0, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, 32'h1, 32'h1111_1111, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, 32'h2, 32'h2222_2222, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, 32'h1, FILL_VALUE, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, 32'h1, 32'h3333_3333, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, KEY_MIN, FILL_VALUE, 1'b0, RESULT_MISS);
    // capacity above the entry count saturates
    add_row(ROW_CAPACITY, lkvc_pkg::FUNC_GET, '0, 32'd31, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, 32'h3, 32'h4444_4444, 1'b0, RESULT_MISS);
    add_row(ROW_CAPACITY, lkvc_pkg::FUNC_GET, '0, 32'd1, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_PUT, 32'h4, 32'h5555_5555, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, 32'h3, FILL_VALUE, 1'b0, RESULT_MISS);
    add_row(ROW_ACCESS, lkvc_pkg::FUNC_GET, 32'h4, FILL_VALUE, 1'b0, RESULT_MISS);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CAPACITY) begin
        wait_drained();
        write_capacity(stim_rows[i].value[lkvc_pkg::CAP_W-1:0]);
      end else begin
        send_access(stim_rows[i].func, stim_rows[i].key, stim_rows[i].value, 0,
                    stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // random part, one capacity setting per phase
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_capacity(cap_t'(cap_seq[p]));
      // pool a little wider than the capacity so both hits and evictions occur
      span = usable_capacity(capacity_reg) + 3;
      for (int n = 0; n < len_seq[p]; n++) begin
        // sender holds off mid phase until all results are back
        if (n == len_seq[p] / 2) wait_drained();
        if ($urandom_range(99) < 4) key_pool[$urandom_range(POOL - 1)] = $urandom;
        func = ($urandom_range(99) < 55) ? lkvc_pkg::FUNC_PUT : lkvc_pkg::FUNC_GET;
        send_access(func, pick_key(span), $urandom, gap_seq[p], 1'b0, RESULT_MISS);
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
